[sv/pl0ls_pkg.sv]
// ----------------------------------------------------------------------------
// pl0ls_pkg
// Shared types and constants of the PL/0 lexical scanner.
// ----------------------------------------------------------------------------
package pl0ls_pkg;

  localparam int DefMaxNameChars = 11;
  localparam int DefMaxNumberDigits = 5;
  localparam int NameStore = 11;

  localparam logic [5:0] KindIdent  = 6'd0;
  localparam logic [5:0] KindNumber = 6'd1;
  localparam logic [5:0] KindWord0  = 6'd2;
  localparam logic [5:0] KindSym0   = 6'd16;

  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrNameLong = 3'd1;
  localparam logic [2:0] ErrNumLong  = 3'd2;
  localparam logic [2:0] ErrDigitLed = 3'd3;
  localparam logic [2:0] ErrBadSym   = 3'd4;
  localparam logic [2:0] ErrReserved = 3'd5;

  // symbol indexes
  localparam logic [4:0] SymPeriod = 5'd0;
  localparam logic [4:0] SymBecomes = 5'd1;
  localparam logic [4:0] SymMinus = 5'd2;
  localparam logic [4:0] SymSemi = 5'd3;
  localparam logic [4:0] SymLBrace = 5'd4;
  localparam logic [4:0] SymRBrace = 5'd5;
  localparam logic [4:0] SymEql = 5'd6;
  localparam logic [4:0] SymNeq = 5'd7;
  localparam logic [4:0] SymLss = 5'd8;
  localparam logic [4:0] SymLeq = 5'd9;
  localparam logic [4:0] SymGtr = 5'd10;
  localparam logic [4:0] SymGeq = 5'd11;
  localparam logic [4:0] SymPlus = 5'd12;
  localparam logic [4:0] SymTimes = 5'd13;
  localparam logic [4:0] SymSlash = 5'd14;
  localparam logic [4:0] SymLParen = 5'd15;
  localparam logic [4:0] SymRParen = 5'd16;

  typedef enum logic [8:0] {
    M_IDLE    = 9'b000000001,
    M_NAME    = 9'b000000010,
    M_NUMBER  = 9'b000000100,
    M_SKIP    = 9'b000001000,
    M_COMMENT = 9'b000010000,
    M_COLON   = 9'b000100000,
    M_EQ      = 9'b001000000,
    M_LT      = 9'b010000000,
    M_GT      = 9'b100000000
  } mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [16:0] num;
    logic [3:0]  len;
    logic [87:0] text;
  } lexeme_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // text of a symbol, first character in the low byte
  function automatic logic [15:0] sym_chars(input logic [4:0] idx);
    logic [15:0] t;
    t = 16'h0000;
    unique case (idx)
      SymPeriod:  t = 16'h002E;
      SymBecomes: t = 16'h3D3A;
      SymMinus:   t = 16'h002D;
      SymSemi:    t = 16'h003B;
      SymLBrace:  t = 16'h007B;
      SymRBrace:  t = 16'h007D;
      SymEql:     t = 16'h3D3D;
      SymNeq:     t = 16'h3E3C;
      SymLss:     t = 16'h003C;
      SymLeq:     t = 16'h3D3C;
      SymGtr:     t = 16'h003E;
      SymGeq:     t = 16'h3D3E;
      SymPlus:    t = 16'h002B;
      SymTimes:   t = 16'h002A;
      SymSlash:   t = 16'h002F;
      SymLParen:  t = 16'h0028;
      SymRParen:  t = 16'h0029;
      default:    t = 16'h0000;
    endcase
    return t;
  endfunction

  function automatic lexeme_t mk_symbol(input logic [4:0] idx);
    lexeme_t l;
    l = '0;
    l.kind = KindSym0 + {1'b0, idx};
    l.text[15:0] = sym_chars(idx);
    l.len = (l.text[15:8] != 8'h00) ? 4'd2 : 4'd1;
    return l;
  endfunction

  function automatic lexeme_t mk_error(input logic [2:0] e);
    lexeme_t l;
    l = '0;
    l.err = e;
    return l;
  endfunction

  function automatic lexeme_t mk_number(input logic [16:0] v);
    lexeme_t l;
    l = '0;
    l.kind = KindNumber;
    l.num = v;
    return l;
  endfunction

  // reserved words as 88-bit text with their lengths
  function automatic logic [87:0] word_text(input int i);
    logic [87:0] t;
    t = '0;
    unique case (i)
      0:  t[39:0] = 40'h74736E6F63;          // const
      1:  t[23:0] = 24'h726176;              // var
      2:  t[71:0] = 72'h657275646563_6F7270; // procedure
      3:  t[31:0] = 32'h6C6C6163;            // call
      4:  t[39:0] = 40'h6E69676562;          // begin
      5:  t[23:0] = 24'h646E65;              // end
      6:  t[15:0] = 16'h6669;                // if
      7:  t[31:0] = 32'h6E656874;            // then
      8:  t[31:0] = 32'h65736C65;            // else
      9:  t[39:0] = 40'h656C696877;          // while
      10: t[15:0] = 16'h6F64;                // do
      11: t[31:0] = 32'h64616572;            // read
      12: t[39:0] = 40'h6574697277;          // write
      13: t[23:0] = 24'h666564;              // def
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] word_len(input int i);
    logic [3:0] n;
    unique case (i)
      0, 4, 9, 12: n = 4'd5;
      1, 5, 13:    n = 4'd3;
      2:           n = 4'd9;
      3, 7, 8, 11: n = 4'd4;
      6, 10:       n = 4'd2;
      default:     n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

[sv/pl0_lexical_scanner_unit.sv]
// ----------------------------------------------------------------------------
// pl0_lexical_scanner_unit
// PL/0 lexical scanner: one source character in, up to two lexemes out.
// ----------------------------------------------------------------------------
// channel | dir | tdata                         | tuser | tlast
// s_axis  | in  | char_code                     | -     | end_of_text
// m_axis  | out | token_kind..text_tail packed  | -     | last_of_run
//
// One character per cycle when the buffer has room; a character yielding two
// lexemes holds off the next until only the second is left in the buffer, and
// a name closed by end of text is emitted from a flush cycle that holds off
// input. The scan state updates on an accepted character and its lexemes
// land in a two-entry output buffer at the same edge. rst is synchronous and
// clears the scan mode, counters and buffer. Input needs room for two
// lexemes, so a stalled output blocks input as soon as it holds a lexeme.
// ----------------------------------------------------------------------------
module pl0_lexical_scanner_unit import pl0ls_pkg::*; #(
  parameter int MAX_NAME_CHARS = DefMaxNameChars,
  parameter int MAX_NUMBER_DIGITS = DefMaxNumberDigits
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // char_code
  input  logic         s_axis_tlast,  // end_of_text
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // token_kind[5:0] error_code[8:6] lex_value[25:9] text_length[29:26]
  // text_head[77:30] text_tail[117:78], zero fill [119:118]
  output logic [119:0] m_axis_tdata,
  output logic         m_axis_tlast   // last_of_run
);

  localparam int NameCntW = $clog2(NameStore + 1);
  localparam int DigCntW = $clog2(MAX_NUMBER_DIGITS + 1);

  mode_t mode, mode_next;
  logic [7:0] name_chars [NameStore];
  logic [NameCntW-1:0] name_count, name_count_next;
  logic name_overflow, name_overflow_next;
  logic [16:0] digit_value, digit_value_next;
  logic [DigCntW-1:0] digit_count, digit_count_next;
  logic name_wr;
  logic [NameCntW-1:0] name_wr_idx;

  // a name flushed at end of text is emitted in the following cycle from a
  // pending flag, since its text is in the store only after the write
  logic flush_name;

  // output buffer: slot 0 presented, slot 1 behind it
  lexeme_t buf_lex [2];
  logic    buf_last [2];
  logic [1:0] buf_cnt;

  lexeme_t r0, r1;
  logic [1:0] r_cnt;

  logic in_acc, out_acc;
  logic [7:0] c;
  logic alpha, digit;
  lexeme_t name_lex;
  logic [87:0] name_text;

  assign c = s_axis_tdata;
  assign alpha = is_alpha(c);
  assign digit = is_digit(c);
  assign out_acc = m_axis_tvalid && m_axis_tready;
  // room for two lexemes after this cycle's output transaction
  assign s_axis_tready = !flush_name &&
                         ((buf_cnt == 2'd0) || (buf_cnt == 2'd1 && m_axis_tready));
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    name_text = '0;
    for (int i = 0; i < NameStore; i++) begin
      if (i < 32'(name_count)) name_text[8*i +: 8] = name_chars[i];
    end
  end

  // classify the held name
  always_comb begin
    logic hit;
    logic [7:0] lw;
    hit = 1'b0;
    lw = '0;
    name_lex = '0;
    if (name_overflow) begin
      name_lex = mk_error(ErrNameLong);
    end else begin
      for (int i = 0; i < 14; i++) begin
        if (!hit && {4'd0, name_count} == {{(8-NameCntW){1'b0}}, word_len(i)}
            && name_text == word_text(i)) begin
          hit = 1'b1;
          lw = 8'(i);
          name_lex.kind = KindWord0 + lw[5:0];
          name_lex.len = 4'(name_count);
          name_lex.text = name_text;
        end
      end
      if (!hit) begin
        if (name_count == NameCntW'(4) && (name_text[31:0] == 32'h6E69616D
            || name_text[31:0] == 32'h6C6C756E)) begin
          name_lex = mk_error(ErrReserved);
        end else begin
          name_lex.kind = KindIdent;
          name_lex.len = 4'(name_count);
          name_lex.text = name_text;
        end
      end
    end
  end

  // scan one character, then flush on end of text
  always_comb begin
    logic to_idle;
    lexeme_t l;
    mode_next = mode;
    name_count_next = name_count;
    name_overflow_next = name_overflow;
    digit_value_next = digit_value;
    digit_count_next = digit_count;
    name_wr = 1'b0;
    name_wr_idx = '0;
    r0 = '0;
    r1 = '0;
    r_cnt = 2'd0;
    to_idle = 1'b0;
    l = '0;
    unique case (mode)
      M_NAME: begin
        if (alpha || digit) begin
          if (32'(name_count) < MAX_NAME_CHARS) begin
            name_wr = 1'b1;
            name_wr_idx = name_count;
            name_count_next = name_count + 1'b1;
          end else begin
            name_overflow_next = 1'b1;
          end
        end else begin
          r0 = name_lex; r_cnt = 2'd1; to_idle = 1'b1;
        end
      end
      M_NUMBER: begin
        if (digit) begin
          if (32'(digit_count) < MAX_NUMBER_DIGITS) begin
            digit_value_next = 17'(digit_value * 17'd10) + {9'd0, c - 8'h30};
            digit_count_next = digit_count + 1'b1;
          end else begin
            r0 = mk_error(ErrNumLong); r_cnt = 2'd1; mode_next = M_SKIP;
          end
        end else if (alpha) begin
          r0 = mk_error(ErrDigitLed); r_cnt = 2'd1; mode_next = M_SKIP;
        end else begin
          r0 = mk_number(digit_value); r_cnt = 2'd1; to_idle = 1'b1;
        end
      end
      M_SKIP: if (!(alpha || digit)) to_idle = 1'b1;
      M_COMMENT: if (c == 8'h0A) mode_next = M_IDLE;
      M_COLON: begin
        if (c == 8'h3D) begin
          r0 = mk_symbol(SymBecomes); r_cnt = 2'd1; mode_next = M_IDLE;
        end else begin
          r0 = mk_error(ErrBadSym); r_cnt = 2'd1; to_idle = 1'b1;
        end
      end
      M_EQ: begin
        if (c == 8'h3D) begin
          r0 = mk_symbol(SymEql); r_cnt = 2'd1; mode_next = M_IDLE;
        end else begin
          r0 = mk_error(ErrBadSym); r_cnt = 2'd1; to_idle = 1'b1;
        end
      end
      M_LT: begin
        r_cnt = 2'd1;
        if (c == 8'h3E) begin
          r0 = mk_symbol(SymNeq); mode_next = M_IDLE;
        end else if (c == 8'h3D) begin
          r0 = mk_symbol(SymLeq); mode_next = M_IDLE;
        end else begin
          r0 = mk_symbol(SymLss); to_idle = 1'b1;
        end
      end
      M_GT: begin
        r_cnt = 2'd1;
        if (c == 8'h3D) begin
          r0 = mk_symbol(SymGeq); mode_next = M_IDLE;
        end else begin
          r0 = mk_symbol(SymGtr); to_idle = 1'b1;
        end
      end
      M_IDLE: to_idle = 1'b1;
      default: to_idle = 1'b1;
    endcase

    if (to_idle) begin
      mode_next = M_IDLE;
      if (alpha) begin
        name_wr = 1'b1;
        name_wr_idx = '0;
        name_count_next = NameCntW'(1);
        name_overflow_next = 1'b0;
        mode_next = M_NAME;
      end else if (digit) begin
        digit_value_next = {9'd0, c - 8'h30};
        digit_count_next = DigCntW'(1);
        mode_next = M_NUMBER;
      end else if (!is_space(c)) begin
        unique case (c)
          8'h23: mode_next = M_COMMENT;
          8'h3A: mode_next = M_COLON;
          8'h3D: mode_next = M_EQ;
          8'h3C: mode_next = M_LT;
          8'h3E: mode_next = M_GT;
          8'h2E: l = mk_symbol(SymPeriod);
          8'h2D: l = mk_symbol(SymMinus);
          8'h3B: l = mk_symbol(SymSemi);
          8'h7B: l = mk_symbol(SymLBrace);
          8'h7D: l = mk_symbol(SymRBrace);
          8'h2B: l = mk_symbol(SymPlus);
          8'h2A: l = mk_symbol(SymTimes);
          8'h2F: l = mk_symbol(SymSlash);
          8'h28: l = mk_symbol(SymLParen);
          8'h29: l = mk_symbol(SymRParen);
          default: l = mk_error(ErrBadSym);
        endcase
        if (!(c == 8'h23 || c == 8'h3A || c == 8'h3D || c == 8'h3C || c == 8'h3E)) begin
          if (r_cnt == 2'd0) r0 = l; else r1 = l;
          r_cnt = r_cnt + 2'd1;
        end
      end
    end

    // flush at end of text; new name/number state was just set by this char
    if (s_axis_tlast) begin
      l = '0;
      unique case (mode_next)
        M_NAME: begin
          // the name may have been started or extended by this character
          l = '0;
        end
        M_NUMBER: l = mk_number(digit_value_next);
        M_COLON, M_EQ: l = mk_error(ErrBadSym);
        M_LT: l = mk_symbol(SymLss);
        M_GT: l = mk_symbol(SymGtr);
        default: l = '0;
      endcase
      if (mode_next == M_NUMBER || mode_next == M_COLON || mode_next == M_EQ
          || mode_next == M_LT || mode_next == M_GT) begin
        if (r_cnt == 2'd0) r0 = l; else r1 = l;
        r_cnt = r_cnt + 2'd1;
      end
      mode_next = (mode_next == M_NAME) ? M_NAME : M_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && name_wr) name_chars[name_wr_idx] <= c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      name_count <= '0;
      name_overflow <= 1'b0;
      digit_value <= '0;
      digit_count <= '0;
      flush_name <= 1'b0;
    end else begin
      if (flush_name) begin
        mode <= M_IDLE;
        flush_name <= 1'b0;
      end else if (in_acc) begin
        mode <= mode_next;
        name_count <= name_count_next;
        name_overflow <= name_overflow_next;
        digit_value <= digit_value_next;
        digit_count <= digit_count_next;
        flush_name <= s_axis_tlast && mode_next == M_NAME;
      end
    end
  end

  // output buffer; a pending name flush needs the input held off
  logic [1:0] push_cnt;
  lexeme_t p0, p1;
  logic p0_last, p1_last;

  always_comb begin
    push_cnt = 2'd0;
    p0 = r0; p1 = r1;
    p0_last = 1'b0; p1_last = 1'b0;
    if (flush_name) begin
      push_cnt = 2'd1;
      p0 = name_lex;
      p0_last = 1'b1;
    end else if (in_acc) begin
      push_cnt = r_cnt;
      p0_last = (r_cnt == 2'd1) && !(s_axis_tlast && mode_next == M_NAME);
      p1_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    logic [1:0] base;
    if (rst) begin
      buf_cnt <= 2'd0;
    end else begin
      base = buf_cnt - {1'b0, out_acc};
      if (out_acc && buf_cnt == 2'd2) begin
        buf_lex[0] <= buf_lex[1];
        buf_last[0] <= buf_last[1];
      end
      if (push_cnt != 2'd0) begin
        if (base == 2'd0) begin
          buf_lex[0] <= p0; buf_last[0] <= p0_last;
          buf_lex[1] <= p1; buf_last[1] <= p1_last;
        end else begin
          buf_lex[1] <= p0; buf_last[1] <= p0_last;
        end
      end
      buf_cnt <= base + push_cnt;
    end
  end

  // a name that ends at end of text without a following character gets its
  // last flag from the flush cycle; the character's own lexemes then are
  // not last of run
  assign m_axis_tvalid = buf_cnt != 2'd0;
  assign m_axis_tlast = buf_last[0];
  assign m_axis_tdata = {2'b00, buf_lex[0].text, buf_lex[0].len, buf_lex[0].num,
                         buf_lex[0].err, buf_lex[0].kind};

  // input must wait while a name flush is pending
  // (a flush cycle always follows an accept with a free buffer slot)

  ap_count_range: assert property (@(posedge clk) disable iff (rst)
    buf_cnt != 2'd3) else $error("output buffer count out of range");
  ap_ready_room: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> (buf_cnt - {1'b0, out_acc}) == 2'd0 || !(r_cnt == 2'd2))
    else $error("two lexemes accepted without room");
  ap_flush_once: assert property (@(posedge clk) disable iff (rst)
    flush_name |=> !flush_name) else $error("name flush repeated");

endmodule
